### sv/multi_channel_timer_bank_core_assert.svh
// assertion macros used by the timer bank core
`ifndef MULTI_CHANNEL_TIMER_BANK_CORE_ASSERT_SVH
`define MULTI_CHANNEL_TIMER_BANK_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define MTB_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define MTB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/mtb_pkg.sv
package mtb_pkg;

  // entry phase codes
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PENDING = 3'd1,
    PH_RUNNING = 3'd2,
    PH_EXPIRED = 3'd3,
    PH_DYING   = 3'd4
  } phase_t;

  // request operation codes
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_STOP  = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH
  } state_t;

  localparam int unsigned STEP_W = 10;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned IDX_W  = 4;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd10;

  // one timer entry as it travels along the ring
  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   remain;
    logic [TIME_W-1:0]   reload;
    logic                periodic;
    logic [DATA_W-1:0]   data;
  } entry_t;

  // one result waiting for delivery
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic              fired;
    logic [DATA_W-1:0] data;
    logic              status;
  } result_t;

  // flags from the head update unit to the sequencer
  typedef struct packed {
    logic fire;
    logic clr_status;
  } head_flags_t;

endpackage

### sv/multi_channel_timer_bank_core.sv
// Bank of TIMER_COUNT one-shot or periodic timers held in a ring of cells.
// Every start, stop or tick request takes one full turn of the ring, one
// entry passing the head update unit per cycle unless the turn is paused,
// and the final result is handed over after the turn. A tick returns one
// result per timer that fires, in index order, with tlast on the final one,
// and no result when nothing fires; a start or stop returns one result with
// tlast. The turn pauses when a timer fires while a result is already held
// and the output is stalled. Input code 3 is accepted and dropped. tick_step
// may be written through the cfg port while no request is in progress.
module multi_channel_timer_bank_core #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  // configuration write: tick_step
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [9:0]    cfg_data,
  // requests
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,  // timer_index[3:0], interval[35:4],
                                       // loop_mode[36], user_data[100:37]
  input  logic [1:0]    s_axis_tuser,  // func[1:0]
  // results
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [71:0]   m_axis_tdata,  // out_index[3:0], out_data[67:4]
  output logic [1:0]    m_axis_tuser,  // fired[0], status[1]
  output logic          m_axis_tlast
);
  import mtb_pkg::*;

  localparam int unsigned PW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] POS_LAST = PW'(TIMER_COUNT - 1);

  state_t            state, state_next;
  logic [PW-1:0]     pos, pos_next;
  logic              hv, hv_next;
  result_t           hold, hold_next;
  logic              ov, ov_next;
  result_t           out_res, out_res_next;
  logic              out_last, out_last_next;
  logic [STEP_W-1:0] tick_step;

  func_t             op;
  logic [IDX_W-1:0]  req_index;
  logic [TIME_W-1:0] req_interval;
  logic              req_mode;
  logic [DATA_W-1:0] req_data;

  entry_t            q   [TIMER_COUNT];
  entry_t            din [TIMER_COUNT];
  entry_t            head_nxt;
  head_flags_t       flags;
  logic              hit;
  logic              can_push;
  logic              adv;
  logic              ring_en;
  logic              s_accept;
  logic [CW-1:0]     pos_ext;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign pos_ext   = CW'(pos);
  assign hit       = (pos_ext == CW'(req_index));
  assign can_push  = !ov || m_axis_tready;

  // tick step register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_step <= cfg_data;
    end
  end

  // request fields held for the whole turn
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op           <= func_t'(s_axis_tuser);
      req_index    <= s_axis_tdata[3:0];
      req_interval <= s_axis_tdata[35:4];
      req_mode     <= s_axis_tdata[36];
      req_data     <= s_axis_tdata[100:37];
    end
  end

  // ring of timer cells, the head hands its updated entry to the tail
  genvar gi;
  generate
    for (gi = 0; gi < TIMER_COUNT; gi++) begin : g_cell
      if (gi == TIMER_COUNT - 1) begin : g_tail
        assign din[gi] = head_nxt;
      end else begin : g_mid
        assign din[gi] = q[gi+1];
      end
      mtb_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (ring_en),
        .din  (din[gi]),
        .dout (q[gi])
      );
    end
  endgenerate

  mtb_head u_head (
    .op        (op),
    .hit       (hit),
    .tick_step (tick_step),
    .interval  (req_interval),
    .loop_mode (req_mode),
    .user_data (req_data),
    .cur       (q[0]),
    .nxt       (head_nxt),
    .flags     (flags)
  );

  // the turn waits only when a second firing meets a held result and a full output
  assign adv     = !(flags.fire && hv && !can_push);
  assign ring_en = (state == ST_PASS) && adv;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      hv    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      hv    <= hv_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    hold     <= hold_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
  end

  // next state, held result and output register
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    hv_next       = hv;
    hold_next     = hold;
    ov_next       = ov && !m_axis_tready;
    out_res_next  = out_res;
    out_last_next = out_last;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          pos_next = '0;
          if (s_axis_tuser == FN_START || s_axis_tuser == FN_STOP) begin
            hold_next.index  = s_axis_tdata[3:0];
            hold_next.fired  = 1'b0;
            hold_next.data   = '0;
            hold_next.status = 1'b1;
            hv_next          = 1'b1;
            state_next       = ST_PASS;
          end else if (s_axis_tuser == FN_TICK) begin
            hv_next    = 1'b0;
            state_next = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (adv) begin
          pos_next = (pos == POS_LAST) ? '0 : pos + 1'b1;
          if (pos == POS_LAST) begin
            state_next = ST_FLUSH;
          end
          if (flags.clr_status) begin
            hold_next.status = 1'b0;
          end
          if (flags.fire) begin
            if (hv) begin
              out_res_next  = hold;
              out_last_next = 1'b0;
              ov_next       = 1'b1;
            end
            hold_next.index  = pos_ext[IDX_W-1:0];
            hold_next.fired  = 1'b1;
            hold_next.data   = q[0].data;
            hold_next.status = 1'b0;
            hv_next          = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!hv) begin
          state_next = ST_IDLE;
        end else if (can_push) begin
          out_res_next  = hold;
          out_last_next = 1'b1;
          ov_next       = 1'b1;
          hv_next       = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {4'b0, out_res.data, out_res.index};
  assign m_axis_tuser  = {out_res.status, out_res.fired};
  assign m_axis_tlast  = out_last;

`include "multi_channel_timer_bank_core_assert.svh"

  `MTB_ASSERT_NOW(a_idle_no_hold, state == ST_IDLE, !hv, "result held while idle")
  `MTB_ASSERT_NEXT(a_accept_starts_turn, s_accept && s_axis_tuser == FN_TICK, state == ST_PASS && pos == '0, "tick did not start a turn at the first cell")
  `MTB_ASSERT_NEXT(a_turn_ends, state == ST_PASS && pos == POS_LAST && adv, state == ST_FLUSH, "turn did not end after the last cell")
  `MTB_ASSERT_NOW(a_flush_home, state == ST_FLUSH, pos == '0, "ring not back home at the end of a turn")
  `MTB_ASSERT_NEXT(a_stall_holds_ring, state == ST_PASS && !adv, pos == $past(pos), "ring moved while the output was blocked")

endmodule

### sv/mtb_cell.sv
module mtb_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  mtb_pkg::entry_t din,
  output mtb_pkg::entry_t dout
);
  import mtb_pkg::*;

  entry_t st;

  // entry storage, takes the neighbor's entry when the ring moves
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
    end else if (en) begin
      st <= din;
    end
  end

  assign dout = st;

endmodule

### sv/mtb_head.sv
module mtb_head (
  input  mtb_pkg::func_t                  op,
  input  logic                            hit,
  input  logic [mtb_pkg::STEP_W-1:0]      tick_step,
  input  logic [mtb_pkg::TIME_W-1:0]      interval,
  input  logic                            loop_mode,
  input  logic [mtb_pkg::DATA_W-1:0]      user_data,
  input  mtb_pkg::entry_t                 cur,
  output mtb_pkg::entry_t                 nxt,
  output mtb_pkg::head_flags_t            flags
);
  import mtb_pkg::*;

  logic [TIME_W-1:0] step_ext;

  assign step_ext = {{(TIME_W-STEP_W){1'b0}}, tick_step};

  // update of the entry that sits at the head of the ring
  always_comb begin
    nxt   = cur;
    flags = '0;
    unique case (op)
      FN_START: begin
        if (hit) begin
          nxt.phase    = PH_PENDING;
          nxt.remain   = interval;
          nxt.reload   = interval;
          nxt.periodic = loop_mode;
          nxt.data     = user_data;
          flags.clr_status = 1'b1;
        end
      end
      FN_STOP: begin
        if (hit && cur.phase != PH_IDLE) begin
          flags.clr_status = 1'b1;
          nxt.phase = (cur.phase == PH_PENDING) ? PH_IDLE : PH_DYING;
        end
      end
      FN_TICK: begin
        case (cur.phase) inside
          PH_IDLE: begin
            nxt.phase = PH_IDLE;
          end
          PH_PENDING, PH_RUNNING: begin
            if (cur.remain <= step_ext) begin
              flags.fire = 1'b1;
              if (cur.periodic) begin
                nxt.remain = cur.reload;
                nxt.phase  = PH_RUNNING;
              end else begin
                nxt.remain = '0;
                nxt.phase  = PH_EXPIRED;
              end
            end else begin
              nxt.remain = cur.remain - step_ext;
              nxt.phase  = PH_RUNNING;
            end
          end
          PH_EXPIRED: begin
            nxt.phase = PH_DYING;
          end
          default: begin
            nxt.phase = PH_IDLE;
          end
        endcase
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### tb/multi_channel_timer_bank_core_tb.sv
module multi_channel_timer_bank_core_tb;
  import mtb_pkg::*;

  localparam int unsigned TIMER_COUNT  = 16;
  localparam int          QUIET_CYCLES = 2 * (TIMER_COUNT + 2) + 4;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          PHASES       = 6;

  // func value with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // one request as it goes onto the input stream
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  index;
    logic [31:0] interval;
    logic        loop_mode;
    logic [63:0] user_data;
  } timer_req_t;

  // one report as it comes back from the bank
  typedef struct packed {
    logic [3:0]  index;
    logic        fired;
    logic [63:0] data;
    logic        status;
    logic        last;
  } timer_report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [9:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // shadow copy of the bank
  phase_t       bank_phase    [TIMER_COUNT];
  logic [31:0]  bank_remain   [TIMER_COUNT];
  logic [31:0]  bank_reload   [TIMER_COUNT];
  logic         bank_periodic [TIMER_COUNT];
  logic [63:0]  bank_data     [TIMER_COUNT];
  logic [9:0]   bank_step;

  timer_req_t    request_q[$];
  timer_report_t owed_reports[$];
  timer_req_t    cur_req;
  timer_report_t want;

  int           error_count  = 0;
  int           sent_count   = 0;
  int           queued_count = 0;
  int           report_count = 0;
  int           fire_count   = 0;
  int           cycle_count  = 0;
  int           burst_left   = 1;
  int           gap_left     = 0;
  bit           no_idle      = 1'b0;
  logic [15:0]  ready_pattern = '1;
  logic [3:0]   ready_pos     = '0;
  logic [9:0]   step_plan [PHASES];

  multi_channel_timer_bank_core #(
    .TIMER_COUNT(TIMER_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one accepted request to the shadow bank and queue the reports it owes
  function automatic void bank_apply(timer_req_t r);
    timer_report_t rep;
    timer_report_t fires[$];
    phase_t        ph;
    logic          stat;
    case (r.func)
      FN_START: begin
        bank_phase[r.index]    = PH_PENDING;
        bank_remain[r.index]   = r.interval;
        bank_reload[r.index]   = r.interval;
        bank_periodic[r.index] = r.loop_mode;
        bank_data[r.index]     = r.user_data;
        rep = '{r.index, 1'b0, 64'd0, 1'b0, 1'b1};
        owed_reports.push_back(rep);
      end
      FN_STOP: begin
        stat = 1'b0;
        if (bank_phase[r.index] == PH_IDLE) stat = 1'b1;
        else if (bank_phase[r.index] == PH_PENDING) bank_phase[r.index] = PH_IDLE;
        else bank_phase[r.index] = PH_DYING;
        rep = '{r.index, 1'b0, 64'd0, stat, 1'b1};
        owed_reports.push_back(rep);
      end
      FN_TICK: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          ph = bank_phase[i];
          if (ph == PH_IDLE) continue;
          // a pending entry starts counting in the same tick
          if (ph == PH_PENDING) ph = PH_RUNNING;
          if (ph == PH_RUNNING) begin
            if (bank_remain[i] <= {22'd0, bank_step}) begin
              rep = '{4'(i), 1'b1, bank_data[i], 1'b0, 1'b0};
              fires.push_back(rep);
              if (bank_periodic[i]) begin
                bank_remain[i] = bank_reload[i];
              end else begin
                bank_remain[i] = '0;
                ph = PH_EXPIRED;
              end
            end else begin
              bank_remain[i] = bank_remain[i] - {22'd0, bank_step};
            end
          end else if (ph == PH_EXPIRED) begin
            ph = PH_DYING;
          end else begin
            ph = PH_IDLE;
          end
          bank_phase[i] = ph;
        end
        if (fires.size() != 0) fires[fires.size()-1].last = 1'b1;
        foreach (fires[j]) owed_reports.push_back(fires[j]);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      error_count++;
    end
  endfunction

  task automatic queue_req(logic [1:0] func, logic [3:0] idx, logic [31:0] interval,
                           logic mode, logic [63:0] data);
    timer_req_t r;
    r = '{func, idx, interval, mode, data};
    request_q.push_back(r);
    if (func != FN_UNUSED) queued_count++;
  endtask

  // intervals mostly a few steps long so that timers fire often
  function automatic logic [31:0] random_interval();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom);
      default: return 32'(bank_step) * $urandom_range(0, 4) + $urandom_range(0, bank_step);
    endcase
  endfunction

  function automatic logic [63:0] random_data();
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic queue_tick();
    queue_req(FN_TICK, 4'($urandom), 32'($urandom), 1'($urandom), random_data());
  endtask

  // random traffic: short timer sessions, full bank sessions and noise
  task automatic gen_phase(int quota);
    int         base;
    int         kind;
    int         k;
    logic [3:0] idx;
    logic [3:0] picks[$];
    base = queued_count;
    while (queued_count - base < quota) begin
      kind = $urandom_range(0, 99);
      picks.delete();
      if (kind < 55) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          idx = 4'($urandom);
          picks.push_back(idx);
          queue_req(FN_START, idx, random_interval(), 1'($urandom), random_data());
        end
        repeat ($urandom_range(1, 5)) queue_tick();
        if ($urandom_range(0, 1) == 1)
          queue_req(FN_STOP, picks[$urandom_range(0, k-1)], 32'($urandom), 1'($urandom),
                    random_data());
        repeat ($urandom_range(1, 3)) queue_tick();
      end else if (kind < 65) begin
        // every entry firing on the same tick
        for (int i = 0; i < TIMER_COUNT; i++)
          queue_req(FN_START, 4'(i), $urandom_range(0, 1) ? 32'd0 : 32'(bank_step),
                    $urandom_range(0, 3) != 0, random_data());
        repeat ($urandom_range(2, 3)) queue_tick();
        for (int i = 0; i < TIMER_COUNT; i++)
          queue_req(FN_STOP, 4'(i), 32'($urandom), 1'($urandom), random_data());
        repeat (2) queue_tick();
      end else begin
        queue_req(2'($urandom_range(0, 3)), 4'($urandom), 32'($urandom), 1'($urandom),
                  random_data());
      end
    end
  endtask

  // wait until every request is in and every report is out, then let the ring settle
  task automatic wait_bank_quiet();
    do @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || owed_reports.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // request driver with bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bank_apply(cur_req);
        sent_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || request_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_req.user_data, cur_req.loop_mode,
                            cur_req.interval, cur_req.index};
          s_axis_tuser  <= cur_req.func;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            if (no_idle) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(8, 30);
            else gap_left = $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // report monitor with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_reports.size() == 0) begin
          $display("%0t: report with nothing owed, expected none, actual index %h data %h",
                   $time, m_axis_tdata[3:0], m_axis_tdata[67:4]);
          error_count++;
        end else begin
          want = owed_reports.pop_front();
          check_field("out_index", 64'(want.index), 64'(m_axis_tdata[3:0]));
          check_field("fired", 64'(want.fired), 64'(m_axis_tuser[0]));
          check_field("out_data", want.data, m_axis_tdata[67:4]);
          check_field("status", 64'(want.status), 64'(m_axis_tuser[1]));
          check_field("last", 64'(want.last), 64'(m_axis_tlast));
          report_count++;
          if (want.fired) fire_count++;
        end
      end
      if (ready_pos == 4'd0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom) | 16'($urandom);
          default: ready_pattern = 16'($urandom) & 16'($urandom);
        endcase
      end
      m_axis_tready <= no_idle || ready_pattern[ready_pos];
      ready_pos = ready_pos + 4'd1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    bank_step = TICK_STEP_RESET;
    foreach (bank_phase[i]) begin
      bank_phase[i]    = PH_IDLE;
      bank_remain[i]   = '0;
      bank_reload[i]   = '0;
      bank_periodic[i] = 1'b0;
      bank_data[i]     = '0;
    end
    step_plan = '{10'd10, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd10};
    step_plan[PHASES-1] = 10'($urandom_range(1, 1000));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset step
    queue_req(FN_START, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_START, 4'd15, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(FN_STOP, 4'd5, 32'd0, 1'b0, 64'd0);
    queue_req(FN_UNUSED, 4'd7, 32'($urandom), 1'b1, random_data());
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_STOP, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_STOP, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_START, 4'd3, 32'd100, 1'b0, 64'h0123_4567_89AB_CDEF);
    queue_req(FN_STOP, 4'd3, 32'd0, 1'b0, 64'd0);
    queue_req(FN_START, 4'd1, 32'd10, 1'b1, 64'hA5A5_A5A5_5A5A_5A5A);
    queue_req(FN_START, 4'd2, 32'd11, 1'b0, 64'h5A5A_5A5A_A5A5_A5A5);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_START, 4'd2, 32'd25, 1'b1, 64'hDEAD_BEEF_0000_0001);
    queue_req(FN_START, 4'd1, 32'd5, 1'b0, 64'h8000_0000_0000_0000);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_STOP, 4'd15, 32'd0, 1'b0, 64'd0);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_STOP, 4'd1, 32'd0, 1'b0, 64'd0);
    queue_req(FN_TICK, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_req(FN_STOP, 4'd2, 32'd0, 1'b0, 64'd0);
    queue_req(FN_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(FN_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);

    // random phases, one tick_step setting each
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_bank_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= step_plan[p];
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        bank_step = step_plan[p];
      end
      no_idle = (p == 3);
      gen_phase(58);
    end
    wait_bank_quiet();

    $display("covered %0d requests over %0d tick_step settings (0 and 1023 among them)",
             sent_count, PHASES);
    $display("checked %0d reports, %0d of them timer expiries", report_count, fire_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### multi_channel_timer_bank_core.f
+incdir+sv
sv/mtb_pkg.sv
sv/mtb_cell.sv
sv/mtb_head.sv
sv/multi_channel_timer_bank_core.sv
tb/multi_channel_timer_bank_core_tb.sv
